[design/vrt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrt_pkg: shared types and constants for the voxel ray traversal core
// Field widths, configuration reset values, command/status words between the
// controller and the datapath, and the product job table.
// ----------------------------------------------------------------------------
package vrt_pkg;

  // Coordinate and index width (two's complement)
  localparam int CW     = 32;
  // Configuration register widths
  localparam int VS_W   = 31;
  localparam int MS_W   = 6;
  localparam int DL_W   = 16;
  localparam int CFG_W  = 31;
  // |hit - origin| per axis fits in CW bits
  localparam int AD_W   = 32;
  // First boundary distance, at most one voxel edge
  localparam int NUM_W  = 31;
  // num * |d| and edge * |d|
  localparam int PROD_W = 63;
  // Cross products grow by up to 63 voxel edges during a walk
  localparam int PP_W   = 70;
  // Gate sum of three squares, each of a value below 2^16
  localparam int SUM_W  = 34;

  localparam logic [MS_W-1:0] STEP_CAP = 6'd62;

  localparam logic [VS_W-1:0] VS_RESET = 31'd19661;
  localparam logic [MS_W-1:0] MS_RESET = 6'd30;
  localparam logic [DL_W-1:0] DL_RESET = 16'd100;

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_EDGE_LEN   = 2'd0;
  localparam logic [1:0] CFG_MAX_STEPS  = 2'd1;
  localparam logic [1:0] CFG_DIST_LIMIT = 2'd2;

  // Product jobs: six cross terms num[a]*|d[b]|, then edge*|d[b]|
  localparam logic [3:0] JOB_LAST  = 4'd8;
  localparam logic [3:0] JOB_EDGE0 = 4'd6;
  localparam logic [2:0] DIV_LAST  = 3'd5;
  localparam logic [1:0] AXIS_LAST = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       div_start;
    logic       div_store;
    logic [2:0] div_sel;
    logic       setup;
    logic       gate_en;
    logic [1:0] gate_axis;
    logic       gate_final;
    logic       mul_start;
    logic       mul_store;
    logic [3:0] mul_job;
    logic       walk_cmp;
    logic       walk_step;
    logic       emit_end;
  } vrt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic go;
    logic walk_done;
  } vrt_sts_t;

  // Axis whose boundary distance feeds the job
  function automatic logic [1:0] job_a(input logic [3:0] job);
    logic [1:0] a;
    case (job)
      4'd0, 4'd1: a = 2'd0;
      4'd2, 4'd3: a = 2'd1;
      default:    a = 2'd2;
    endcase
    return a;
  endfunction

  // Axis whose |d| feeds the job
  function automatic logic [1:0] job_b(input logic [3:0] job);
    logic [1:0] b;
    case (job)
      4'd0: b = 2'd1;
      4'd1: b = 2'd2;
      4'd2: b = 2'd0;
      4'd3: b = 2'd2;
      4'd4: b = 2'd0;
      4'd5: b = 2'd1;
      4'd6: b = 2'd0;
      4'd7: b = 2'd1;
      default: b = 2'd2;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

[design/vrt_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrt_div: radix-2 restoring divider
// Unsigned 32-bit dividend by 31-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vrt_div
  import vrt_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [CW-1:0]     dividend_i,
  input  wire logic [VS_W-1:0]   divisor_i,
  output logic                   done_o,
  output logic [CW-1:0]          quot_o,
  output logic [VS_W-1:0]        rem_o
);

  logic              busy_q;
  logic              done_q;
  logic [4:0]        cnt_q;
  logic [CW-1:0]     quot_q;
  logic [VS_W-1:0]   rem_q;
  logic [CW-1:0]     trial;
  logic              ge;
  logic [CW-1:0]     diff;

  // shift in next dividend bit and try the subtract
  assign trial = {rem_q, quot_q[CW-1]};
  assign ge    = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'd0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd31;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // quotient and remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      quot_q <= {quot_q[CW-2:0], ge};
      rem_q  <= ge ? diff[VS_W-1:0] : trial[VS_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

[design/vrt_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrt_mul: serial shift-add multiplier
// 31-bit by 32-bit unsigned product, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module vrt_mul
  import vrt_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [NUM_W-1:0]   a_i,
  input  wire logic [AD_W-1:0]    b_i,
  output logic                    done_o,
  output logic [PROD_W-1:0]       prod_o
);

  logic              busy_q;
  logic              done_q;
  logic [4:0]        cnt_q;
  logic [AD_W-1:0]   hi_q;
  logic [AD_W-1:0]   lo_q;
  logic [AD_W:0]     sum;

  // add multiplicand when the low bit is set
  assign sum = {1'b0, hi_q} + (lo_q[0] ? {2'b00, a_i} : '0);

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'd0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd31;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // product shifts right one bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= sum[AD_W:1];
      lo_q <= {sum[0], lo_q[AD_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q[NUM_W-1:0], lo_q};

endmodule
`default_nettype wire

[design/vrt_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrt_dp: traversal datapath
// Configuration registers, floor division to voxel indices, distance gate,
// exact crossing-time cross products and the voxel walk with result words.
// ----------------------------------------------------------------------------
module vrt_dp
  import vrt_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire vrt_cmd_t           cmd_i,
  output vrt_sts_t                sts_o,
  input  wire logic [CW-1:0]      origin_x_i,
  input  wire logic [CW-1:0]      origin_y_i,
  input  wire logic [CW-1:0]      origin_z_i,
  input  wire logic [CW-1:0]      hit_x_i,
  input  wire logic [CW-1:0]      hit_y_i,
  input  wire logic [CW-1:0]      hit_z_i,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [CFG_W-1:0]   cfg_data_i,
  output logic                    result_valid_o,
  output logic [CW-1:0]           voxel_x_o,
  output logic [CW-1:0]           voxel_y_o,
  output logic [CW-1:0]           voxel_z_o,
  output logic                    update_kind_o,
  output logic                    last_o
);

  // configuration
  logic [VS_W-1:0]   vs_q;
  logic [MS_W-1:0]   ms_q;
  logic [DL_W-1:0]   dl_q;
  logic [VS_W-1:0]   vs_eff;
  logic [MS_W-1:0]   cap;

  // ray state
  logic [CW-1:0]     coord_q [6];
  logic [CW-1:0]     cur_q   [3];
  logic [CW-1:0]     tgt_q   [3];
  logic [VS_W-1:0]   rem_q   [3];
  logic [NUM_W-1:0]  num_q   [3];
  logic [AD_W-1:0]   ad_q    [3];
  logic [2:0]        neg_q;
  logic [2:0]        nz_q;
  logic [PP_W-1:0]   pp_q    [3][3];
  logic [PROD_W-1:0] vv_q    [3];
  logic              go_q;
  logic [SUM_W-1:0]  sum_q;
  logic [MS_W-1:0]   iters_q;
  logic [1:0]        ax_q;

  // result word
  logic              out_valid_q;
  logic [CW-1:0]     out_x_q;
  logic [CW-1:0]     out_y_q;
  logic [CW-1:0]     out_z_q;
  logic              out_kind_q;
  logic              out_last_q;

  // divider hookup
  logic [CW-1:0]     div_src;
  logic              div_neg;
  logic [CW-1:0]     dividend;
  logic              div_done;
  logic [CW-1:0]     div_q;
  logic [VS_W-1:0]   div_r;
  logic [CW-1:0]     floor_q;
  logic [VS_W-1:0]   floor_r;
  logic [1:0]        tsel;

  // multiplier hookup
  logic [1:0]        ja;
  logic [1:0]        jb;
  logic [NUM_W-1:0]  mul_a;
  logic              mul_done;
  logic [PROD_W-1:0] mul_p;

  // setup terms
  logic [CW:0]       d_s   [3];
  logic [AD_W-1:0]   ad_s  [3];
  logic [NUM_W-1:0]  num_s [3];

  // gate terms
  logic [CW:0]       df;
  logic [CW:0]       dm;
  logic              dm_ok;
  logic [31:0]       dsq;
  logic [31:0]       dl_sq;

  // walk terms
  logic              at_tgt;
  logic              e10;
  logic [1:0]        ax1;
  logic [PP_W-1:0]   p2a;
  logic [PP_W-1:0]   pa2;
  logic              nz_a;
  logic              e2;
  logic [1:0]        ax_d;

  assign vs_eff = (vs_q == '0) ? {{(VS_W-1){1'b0}}, 1'b1} : vs_q;
  assign cap    = (ms_q > STEP_CAP) ? STEP_CAP : ms_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= VS_RESET;
      ms_q <= MS_RESET;
      dl_q <= DL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EDGE_LEN:   vs_q <= cfg_data_i[VS_W-1:0];
        CFG_MAX_STEPS:  ms_q <= cfg_data_i[MS_W-1:0];
        CFG_DIST_LIMIT: dl_q <= cfg_data_i[DL_W-1:0];
        default: ;
      endcase
    end
  end

  // floor division: divide magnitude, then fix up for negative inputs
  assign div_src  = coord_q[cmd_i.div_sel];
  assign div_neg  = div_src[CW-1];
  assign dividend = div_neg ? (CW'(0) - div_src) : div_src;
  assign tsel     = 2'(cmd_i.div_sel - 3'd3);

  vrt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (vs_eff),
    .done_o     (div_done),
    .quot_o     (div_q),
    .rem_o      (div_r)
  );

  always_comb begin
    if (div_neg && (div_r != '0)) begin
      floor_q = ~div_q;
      floor_r = vs_eff - div_r;
    end else if (div_neg) begin
      floor_q = CW'(0) - div_q;
      floor_r = div_r;
    end else begin
      floor_q = div_q;
      floor_r = div_r;
    end
  end

  // direction and first boundary distance per axis
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_s[i]  = {coord_q[i+3][CW-1], coord_q[i+3]} - {coord_q[i][CW-1], coord_q[i]};
      ad_s[i] = d_s[i][CW] ? AD_W'((CW+1)'(0) - d_s[i]) : d_s[i][AD_W-1:0];
      if (d_s[i][CW]) begin
        num_s[i] = rem_q[i];
      end else if (d_s[i] != '0) begin
        num_s[i] = vs_eff - rem_q[i];
      end else begin
        num_s[i] = '0;
      end
    end
  end

  // distance gate, one axis a cycle
  assign df    = {tgt_q[cmd_i.gate_axis][CW-1], tgt_q[cmd_i.gate_axis]}
               - {cur_q[cmd_i.gate_axis][CW-1], cur_q[cmd_i.gate_axis]};
  assign dm    = df[CW] ? ((CW+1)'(0) - df) : df;
  assign dm_ok = dm < {{(CW+1-DL_W){1'b0}}, dl_q};
  assign dsq   = dm[DL_W-1:0] * dm[DL_W-1:0];
  assign dl_sq = dl_q * dl_q;

  // cross-product jobs on the serial multiplier
  assign ja    = job_a(cmd_i.mul_job);
  assign jb    = job_b(cmd_i.mul_job);
  assign mul_a = (cmd_i.mul_job < JOB_EDGE0) ? num_q[ja] : vs_eff;

  vrt_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (ad_q[jb]),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  // axis choice: earliest boundary crossing, lower axis on a tie
  assign at_tgt = (cur_q[0] == tgt_q[0]) && (cur_q[1] == tgt_q[1]) && (cur_q[2] == tgt_q[2]);
  assign e10    = nz_q[1] && (!nz_q[0] || (pp_q[1][0] < pp_q[0][1]));
  assign ax1    = e10 ? 2'd1 : 2'd0;
  assign p2a    = e10 ? pp_q[2][1] : pp_q[2][0];
  assign pa2    = e10 ? pp_q[1][2] : pp_q[0][2];
  assign nz_a   = e10 ? nz_q[1] : nz_q[0];
  assign e2     = nz_q[2] && (!nz_a || (p2a < pa2));
  assign ax_d   = e2 ? 2'd2 : ax1;

  // ray registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      coord_q[0] <= origin_x_i;
      coord_q[1] <= origin_y_i;
      coord_q[2] <= origin_z_i;
      coord_q[3] <= hit_x_i;
      coord_q[4] <= hit_y_i;
      coord_q[5] <= hit_z_i;
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          pp_q[a][b] <= '0;
        end
      end
    end
    if (cmd_i.div_store) begin
      if (cmd_i.div_sel < 3'd3) begin
        cur_q[cmd_i.div_sel[1:0]] <= floor_q;
        rem_q[cmd_i.div_sel[1:0]] <= floor_r;
      end else begin
        tgt_q[tsel] <= floor_q;
      end
    end
    if (cmd_i.setup) begin
      for (int i = 0; i < 3; i++) begin
        neg_q[i] <= d_s[i][CW];
        nz_q[i]  <= d_s[i] != '0;
        ad_q[i]  <= ad_s[i];
        num_q[i] <= num_s[i];
      end
    end
    if (cmd_i.mul_store) begin
      if (cmd_i.mul_job < JOB_EDGE0) begin
        pp_q[ja][jb] <= PP_W'(mul_p);
      end else begin
        vv_q[jb] <= mul_p;
      end
    end
    if (cmd_i.walk_cmp) begin
      ax_q <= ax_d;
    end
    // advance one voxel along the chosen axis
    if (cmd_i.walk_step) begin
      for (int i = 0; i < 3; i++) begin
        if (ax_q == 2'(i)) begin
          if (neg_q[i]) begin
            cur_q[i] <= cur_q[i] - CW'(1);
          end else if (nz_q[i]) begin
            cur_q[i] <= cur_q[i] + CW'(1);
          end
          for (int b = 0; b < 3; b++) begin
            if (b != i) begin
              pp_q[i][b] <= pp_q[i][b] + PP_W'(vv_q[b]);
            end
          end
        end
      end
    end
  end

  // gate and step count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go_q    <= 1'b0;
      sum_q   <= '0;
      iters_q <= '0;
    end else begin
      if (cmd_i.setup) begin
        go_q    <= 1'b1;
        sum_q   <= '0;
        iters_q <= '0;
      end
      if (cmd_i.gate_en) begin
        if (!dm_ok) begin
          go_q <= 1'b0;
        end else begin
          sum_q <= sum_q + SUM_W'(dsq);
        end
      end
      if (cmd_i.gate_final && (sum_q >= SUM_W'(dl_sq))) begin
        go_q <= 1'b0;
      end
      if (cmd_i.walk_step) begin
        iters_q <= iters_q + MS_W'(1);
      end
    end
  end

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.walk_cmp || cmd_i.emit_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_cmp) begin
      out_x_q    <= cur_q[0];
      out_y_q    <= cur_q[1];
      out_z_q    <= cur_q[2];
      out_kind_q <= 1'b0;
      out_last_q <= 1'b0;
    end else if (cmd_i.emit_end) begin
      out_x_q    <= tgt_q[0];
      out_y_q    <= tgt_q[1];
      out_z_q    <= tgt_q[2];
      out_kind_q <= 1'b1;
      out_last_q <= 1'b1;
    end
  end

  assign sts_o.div_done  = div_done;
  assign sts_o.mul_done  = mul_done;
  assign sts_o.go        = go_q;
  assign sts_o.walk_done = (iters_q > cap) || at_tgt;

  assign result_valid_o = out_valid_q;
  assign voxel_x_o      = out_x_q;
  assign voxel_y_o      = out_y_q;
  assign voxel_z_o      = out_z_q;
  assign update_kind_o  = out_kind_q;
  assign last_o         = out_last_q;

`ifndef SYNTHESIS
  // the final word of a ray is always the occupied endpoint
  a_last_is_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q |-> out_kind_q)
    else $error("last word without endpoint kind");

  // a step never runs past the iteration cap
  a_step_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_step |-> iters_q <= cap)
    else $error("walk step beyond cap");

  // free words are only emitted away from the endpoint voxel
  a_free_not_tgt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_cmp |-> !at_tgt)
    else $error("free word at endpoint voxel");
`endif

endmodule
`default_nettype wire

[design/vrt_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrt_ctrl: traversal sequencer
// Steps one ray through division, gating, product setup and the voxel walk.
// ----------------------------------------------------------------------------
module vrt_ctrl
  import vrt_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  output vrt_cmd_t       cmd_o,
  input  wire vrt_sts_t  sts_i
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DIV_GO   = 4'd1;
  localparam logic [3:0] S_DIV_WAIT = 4'd2;
  localparam logic [3:0] S_SETUP    = 4'd3;
  localparam logic [3:0] S_GATE     = 4'd4;
  localparam logic [3:0] S_GATE_FIN = 4'd5;
  localparam logic [3:0] S_DECIDE   = 4'd6;
  localparam logic [3:0] S_MUL_GO   = 4'd7;
  localparam logic [3:0] S_MUL_WAIT = 4'd8;
  localparam logic [3:0] S_WALK     = 4'd9;
  localparam logic [3:0] S_STEP     = 4'd10;
  localparam logic [3:0] S_END      = 4'd11;

  logic [3:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.div_sel   = cnt_q[2:0];
    cmd_o.gate_axis = cnt_q[1:0];
    cmd_o.mul_job   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.div_store = 1'b1;
          if (cnt_q[2:0] == DIV_LAST) begin
            state_d = S_SETUP;
          end else begin
            cnt_d   = cnt_q + 4'd1;
            state_d = S_DIV_GO;
          end
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        cnt_d       = '0;
        state_d     = S_GATE;
      end
      S_GATE: begin
        cmd_o.gate_en = 1'b1;
        if (cnt_q[1:0] == AXIS_LAST) begin
          state_d = S_GATE_FIN;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_GATE_FIN: begin
        cmd_o.gate_final = 1'b1;
        cnt_d            = '0;
        state_d          = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = sts_i.go ? S_MUL_GO : S_END;
      end
      S_MUL_GO: begin
        cmd_o.mul_start = 1'b1;
        state_d         = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.mul_store = 1'b1;
          if (cnt_q == JOB_LAST) begin
            state_d = S_WALK;
          end else begin
            cnt_d   = cnt_q + 4'd1;
            state_d = S_MUL_GO;
          end
        end
      end
      S_WALK: begin
        if (sts_i.walk_done) begin
          state_d = S_END;
        end else begin
          cmd_o.walk_cmp = 1'b1;
          state_d        = S_STEP;
        end
      end
      S_STEP: begin
        cmd_o.walk_step = 1'b1;
        state_d         = S_WALK;
      end
      S_END: begin
        cmd_o.emit_end = 1'b1;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy = state_q != S_IDLE;

`ifndef SYNTHESIS
  // divider completes only while its result is awaited
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> state_q == S_DIV_WAIT)
    else $error("divider done outside wait");

  // multiplier completes only while its result is awaited
  a_mul_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.mul_done |-> state_q == S_MUL_WAIT)
    else $error("multiplier done outside wait");

  // an accepted ray is always loaded
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> cmd_o.load)
    else $error("accepted ray not loaded");
`endif

endmodule
`default_nettype wire

[design/voxel_ray_traversal_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_ray_traversal_core: 3D DDA voxel walk from sensor origin to hit point
// Use: raise start with origin and hit (signed Q16.16) while busy is low; the
// ray is taken at that edge and busy stays high until the endpoint word is
// issued; busy falls at the edge that puts the endpoint word on the outputs.
// Each result word shows for one cycle with result_valid_o: free voxels in
// walk order, then the endpoint voxel with update_kind_o and last_o set.
// The receiver cannot stall; every word must be taken when shown.
// Order: six floor divisions (one shared radix-2 divider), the distance
// gate and decide, nine products (one serial multiplier), then one free
// word per voxel walked and the endpoint word. A gated-off ray skips the
// products and walk. One ray at a time; the next start is taken once busy
// falls. Configuration (voxel edge, step cap, distance limit) is written
// through cfg_we_i / cfg_idx_i / cfg_data_i; the user must write it only
// while no ray is in flight, and the block does not enforce this.
// Reset restores 0.3 m voxels, 30 steps, limit 100, and clears the sequencer.
// ----------------------------------------------------------------------------
module voxel_ray_traversal_core
  import vrt_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [CW-1:0]     origin_x_i,
  input  wire logic [CW-1:0]     origin_y_i,
  input  wire logic [CW-1:0]     origin_z_i,
  input  wire logic [CW-1:0]     hit_x_i,
  input  wire logic [CW-1:0]     hit_y_i,
  input  wire logic [CW-1:0]     hit_z_i,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i,
  output logic                   result_valid_o,
  output logic [CW-1:0]          voxel_x_o,
  output logic [CW-1:0]          voxel_y_o,
  output logic [CW-1:0]          voxel_z_o,
  output logic                   update_kind_o,
  output logic                   last_o
);

  vrt_cmd_t cmd;
  vrt_sts_t sts;

  // sequencer
  vrt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  // datapath
  vrt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .origin_x_i     (origin_x_i),
    .origin_y_i     (origin_y_i),
    .origin_z_i     (origin_z_i),
    .hit_x_i        (hit_x_i),
    .hit_y_i        (hit_y_i),
    .hit_z_i        (hit_z_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .voxel_x_o      (voxel_x_o),
    .voxel_y_o      (voxel_y_o),
    .voxel_z_o      (voxel_z_o),
    .update_kind_o  (update_kind_o),
    .last_o         (last_o)
  );

endmodule
`default_nettype wire
